// ===== rtl/ryc_pkg.sv =====
// Shared types for the RGB24 / YUYV pixel pair converter.
package ryc_pkg;

    // One pixel pair on the input side: R0 G0 B0 R1 G1 B1 or Y0 U Y1 V.
    typedef struct packed {
        logic [7:0] in_byte_0;
        logic [7:0] in_byte_1;
        logic [7:0] in_byte_2;
        logic [7:0] in_byte_3;
        logic [7:0] in_byte_4;
        logic [7:0] in_byte_5;
    } in_word_t;

    // One pixel pair on the output side: Y0 U Y1 V 0 0 or R0 G0 B0 R1 G1 B1.
    typedef struct packed {
        logic [7:0] out_byte_0;
        logic [7:0] out_byte_1;
        logic [7:0] out_byte_2;
        logic [7:0] out_byte_3;
        logic [7:0] out_byte_4;
        logic [7:0] out_byte_5;
    } out_word_t;

    // Wide enough for every product and every sum of three products.
    localparam int SUM_W    = 20;
    localparam int NUM_PROD = 12;
    localparam int NUM_SUM  = 6;

    typedef logic signed [SUM_W-1:0] sum_t;
    typedef sum_t prod_arr_t [NUM_PROD];
    typedef sum_t sum_arr_t [NUM_SUM];

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // Control that travels alongside each word through the pipeline.
    typedef struct packed {
        logic valid;
        logic dir;
    } stage_ctl_t;

endpackage

// ===== rtl/ryc_mult.sv =====
// First pipeline stage: constant coefficient products for either direction.
module ryc_mult
(
    input  logic                clk,
    input  logic                rst_n,
    input  ryc_pkg::stage_ctl_t in_ctl,
    input  ryc_pkg::in_word_t   in_word,
    output ryc_pkg::stage_ctl_t out_ctl,
    output ryc_pkg::prod_arr_t  prod
);

    localparam int K_Y_R  = 66;
    localparam int K_Y_G  = 129;
    localparam int K_Y_B  = 25;
    localparam int K_U_R  = 38;
    localparam int K_U_G  = 74;
    localparam int K_UV_B = 112;
    localparam int K_V_R  = 112;
    localparam int K_V_G  = 94;
    localparam int K_V_B  = 18;
    localparam int K_C    = 298;
    localparam int K_R_E  = 409;
    localparam int K_G_D  = 100;
    localparam int K_G_E  = 208;
    localparam int K_B_D  = 516;

    ryc_pkg::stage_ctl_t ctl_reg;
    ryc_pkg::prod_arr_t  prod_reg;
    ryc_pkg::prod_arr_t  prod_next;

    ryc_pkg::sum_t b0, b1, b2, b3, b4, b5;
    ryc_pkg::sum_t c0, c1, d, e;

    always_comb
    begin
        b0 = ryc_pkg::sum_t'({12'd0, in_word.in_byte_0});
        b1 = ryc_pkg::sum_t'({12'd0, in_word.in_byte_1});
        b2 = ryc_pkg::sum_t'({12'd0, in_word.in_byte_2});
        b3 = ryc_pkg::sum_t'({12'd0, in_word.in_byte_3});
        b4 = ryc_pkg::sum_t'({12'd0, in_word.in_byte_4});
        b5 = ryc_pkg::sum_t'({12'd0, in_word.in_byte_5});
        c0 = b0 - ryc_pkg::sum_t'(16);
        c1 = b2 - ryc_pkg::sum_t'(16);
        d  = b1 - ryc_pkg::sum_t'(128);
        e  = b3 - ryc_pkg::sum_t'(128);

        if (in_ctl.dir == ryc_pkg::DIR_ENCODE)
        begin
            prod_next[0]  = b0 * ryc_pkg::sum_t'(K_Y_R);
            prod_next[1]  = b1 * ryc_pkg::sum_t'(K_Y_G);
            prod_next[2]  = b2 * ryc_pkg::sum_t'(K_Y_B);
            prod_next[3]  = b0 * ryc_pkg::sum_t'(K_U_R);
            prod_next[4]  = b1 * ryc_pkg::sum_t'(K_U_G);
            prod_next[5]  = b2 * ryc_pkg::sum_t'(K_UV_B);
            prod_next[6]  = b3 * ryc_pkg::sum_t'(K_Y_R);
            prod_next[7]  = b4 * ryc_pkg::sum_t'(K_Y_G);
            prod_next[8]  = b5 * ryc_pkg::sum_t'(K_Y_B);
            prod_next[9]  = b0 * ryc_pkg::sum_t'(K_V_R);
            prod_next[10] = b1 * ryc_pkg::sum_t'(K_V_G);
            prod_next[11] = b2 * ryc_pkg::sum_t'(K_V_B);
        end
        else
        begin
            // Decoding needs only six products; the chroma terms are shared
            // by both pixels of the pair.
            prod_next[0]  = c0 * ryc_pkg::sum_t'(K_C);
            prod_next[1]  = c1 * ryc_pkg::sum_t'(K_C);
            prod_next[2]  = e * ryc_pkg::sum_t'(K_R_E);
            prod_next[3]  = d * ryc_pkg::sum_t'(K_G_D);
            prod_next[4]  = e * ryc_pkg::sum_t'(K_G_E);
            prod_next[5]  = d * ryc_pkg::sum_t'(K_B_D);
            prod_next[6]  = '0;
            prod_next[7]  = '0;
            prod_next[8]  = '0;
            prod_next[9]  = '0;
            prod_next[10] = '0;
            prod_next[11] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ctl.valid)
        begin
            prod_reg <= prod_next;
        end
    end

    assign out_ctl = ctl_reg;
    assign prod    = prod_reg;

endmodule

// ===== rtl/ryc_sum.sv =====
// Second pipeline stage: combines products into four channel sums when encoding, six when decoding.
module ryc_sum
(
    input  logic                clk,
    input  logic                rst_n,
    input  ryc_pkg::stage_ctl_t in_ctl,
    input  ryc_pkg::prod_arr_t  prod,
    output ryc_pkg::stage_ctl_t out_ctl,
    output ryc_pkg::sum_arr_t   sum
);

    ryc_pkg::stage_ctl_t ctl_reg;
    ryc_pkg::sum_arr_t   sum_reg;
    ryc_pkg::sum_arr_t   sum_next;

    always_comb
    begin
        if (in_ctl.dir == ryc_pkg::DIR_ENCODE)
        begin
            sum_next[0] = prod[0] + prod[1] + prod[2];
            sum_next[1] = prod[5] - prod[3] - prod[4];
            sum_next[2] = prod[6] + prod[7] + prod[8];
            sum_next[3] = prod[9] - prod[10] - prod[11];
            sum_next[4] = '0;
            sum_next[5] = '0;
        end
        else
        begin
            sum_next[0] = prod[0] + prod[2];
            sum_next[1] = prod[0] - prod[3] - prod[4];
            sum_next[2] = prod[0] + prod[5];
            sum_next[3] = prod[1] + prod[2];
            sum_next[4] = prod[1] - prod[3] - prod[4];
            sum_next[5] = prod[1] + prod[5];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ctl.valid)
        begin
            sum_reg <= sum_next;
        end
    end

    assign out_ctl = ctl_reg;
    assign sum     = sum_reg;

endmodule

// ===== rtl/ryc_clamp.sv =====
// Third pipeline stage: scales, offsets and clamps the sums into output bytes.
module ryc_clamp
(
    input  logic                clk,
    input  logic                rst_n,
    input  ryc_pkg::stage_ctl_t in_ctl,
    input  ryc_pkg::sum_arr_t   sum,
    output logic                out_valid,
    output ryc_pkg::out_word_t  out_word
);

    ryc_pkg::stage_ctl_t ctl_reg;
    ryc_pkg::out_word_t  word_reg;
    ryc_pkg::out_word_t  word_next;

    // Floor division by 256 is an arithmetic shift on the signed sum.
    function automatic logic [7:0] sat8(ryc_pkg::sum_t v, ryc_pkg::sum_t off,
                                        ryc_pkg::sum_t lo, ryc_pkg::sum_t hi);
        ryc_pkg::sum_t t;
        t = (v >>> 8) + off;
        if (t < lo)
        begin
            t = lo;
        end
        if (t > hi)
        begin
            t = hi;
        end
        return t[7:0];
    endfunction

    localparam ryc_pkg::sum_t Y_OFF  = ryc_pkg::sum_t'(16);
    localparam ryc_pkg::sum_t Y_LO   = ryc_pkg::sum_t'(16);
    localparam ryc_pkg::sum_t Y_HI   = ryc_pkg::sum_t'(235);
    localparam ryc_pkg::sum_t C_OFF  = ryc_pkg::sum_t'(128);
    localparam ryc_pkg::sum_t C_LO   = ryc_pkg::sum_t'(16);
    localparam ryc_pkg::sum_t C_HI   = ryc_pkg::sum_t'(240);
    localparam ryc_pkg::sum_t RGB_LO = ryc_pkg::sum_t'(0);
    localparam ryc_pkg::sum_t RGB_HI = ryc_pkg::sum_t'(255);

    always_comb
    begin
        if (in_ctl.dir == ryc_pkg::DIR_ENCODE)
        begin
            word_next.out_byte_0 = sat8(sum[0], Y_OFF, Y_LO, Y_HI);
            word_next.out_byte_1 = sat8(sum[1], C_OFF, C_LO, C_HI);
            word_next.out_byte_2 = sat8(sum[2], Y_OFF, Y_LO, Y_HI);
            word_next.out_byte_3 = sat8(sum[3], C_OFF, C_LO, C_HI);
            word_next.out_byte_4 = 8'd0;
            word_next.out_byte_5 = 8'd0;
        end
        else
        begin
            word_next.out_byte_0 = sat8(sum[0], RGB_LO, RGB_LO, RGB_HI);
            word_next.out_byte_1 = sat8(sum[1], RGB_LO, RGB_LO, RGB_HI);
            word_next.out_byte_2 = sat8(sum[2], RGB_LO, RGB_LO, RGB_HI);
            word_next.out_byte_3 = sat8(sum[3], RGB_LO, RGB_LO, RGB_HI);
            word_next.out_byte_4 = sat8(sum[4], RGB_LO, RGB_LO, RGB_HI);
            word_next.out_byte_5 = sat8(sum[5], RGB_LO, RGB_LO, RGB_HI);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ctl.valid)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = ctl_reg.valid;
    assign out_word  = word_reg;

endmodule

// ===== rtl/rgb24_yuyv_pair_converter.sv =====
// Top level of the RGB24 / YUYV pixel pair converter.
// One pixel pair is accepted on every clock in which start is high; busy is
// never raised. Each word leaves on result with a one-cycle done strobe after it
// has passed the three register stages: coefficient products, channel sums, and
// scale-and-clamp. Results cannot be held off, so the receiver must take every
// done cycle. The direction register is sampled with each word as it enters,
// so it should only be changed while no words are in flight.
module rgb24_yuyv_pair_converter
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    input  logic               start,
    output logic               busy,
    input  ryc_pkg::in_word_t  in_word,
    output logic               done,
    output ryc_pkg::out_word_t result
);

    logic                dir_reg;
    ryc_pkg::stage_ctl_t entry_ctl;
    ryc_pkg::stage_ctl_t mult_ctl;
    ryc_pkg::stage_ctl_t sum_ctl;
    ryc_pkg::prod_arr_t  prod;
    ryc_pkg::sum_arr_t   sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg <= ryc_pkg::DIR_ENCODE;
        end
        else if (cfg_we)
        begin
            dir_reg <= cfg_wdata;
        end
    end

    assign busy            = 1'b0;
    assign entry_ctl.valid = start && !busy;
    assign entry_ctl.dir   = dir_reg;

    ryc_mult u_mult
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ctl  (entry_ctl),
        .in_word (in_word),
        .out_ctl (mult_ctl),
        .prod    (prod)
    );

    ryc_sum u_sum
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ctl  (mult_ctl),
        .prod    (prod),
        .out_ctl (sum_ctl),
        .sum     (sum)
    );

    ryc_clamp u_clamp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ctl    (sum_ctl),
        .sum       (sum),
        .out_valid (done),
        .out_word  (result)
    );

    // Every accepted word comes out on result with done raised.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("accepted word did not complete after three cycles");

    // Encoded luma always lands inside the legal video range.
    a_luma_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !$past(dir_reg, 3) && $past(start, 3))
        |-> (result.out_byte_0 >= 8'd16 && result.out_byte_0 <= 8'd235 &&
             result.out_byte_2 >= 8'd16 && result.out_byte_2 <= 8'd235))
        else $error("encoded luma out of range");

    // The two unused bytes of an encoded word are zero.
    a_enc_pad: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !$past(dir_reg, 3) && $past(start, 3))
        |-> (result.out_byte_4 == 8'd0 && result.out_byte_5 == 8'd0))
        else $error("encoded word has nonzero padding bytes");

endmodule

// ===== test/tb_rgb24_yuyv_pair_converter.sv =====
// Self-checking testbench for the RGB24 / YUYV pixel pair converter, with a BT.601 predictor.
module tb_rgb24_yuyv_pair_converter;
    timeunit 1ns;
    timeprecision 1ps;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic               cfg_wdata;
    logic               start;
    logic               busy;
    ryc_pkg::in_word_t  in_word;
    logic               done;
    ryc_pkg::out_word_t result;

    rgb24_yuyv_pair_converter dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .start     (start),
        .busy      (busy),
        .in_word   (in_word),
        .done      (done),
        .result    (result)
    );

    localparam int DRAIN_LIMIT = 64;

    ryc_pkg::out_word_t pending_words[$];
    ryc_pkg::out_word_t oldest_word;
    logic               direction_copy;
    logic               idle_enabled;
    int                 mismatch_count;
    int                 words_checked;
    int                 encode_count;
    int                 decode_count;
    int                 direction_writes;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [7:0] clamp_byte(int v, int lo, int hi);
        if (v < lo)
            v = lo;
        if (v > hi)
            v = hi;
        return v[7:0];
    endfunction

    // Arithmetic shift on a signed int is a floor division by 256.
    function automatic logic [7:0] luma_of(int r, int g, int b);
        return clamp_byte(((66 * r + 129 * g + 25 * b) >>> 8) + 16, 16, 235);
    endfunction

    function automatic logic [23:0] rgb_of(int c, int d, int e);
        logic [23:0] rgb;
        rgb[23:16] = clamp_byte((298 * c + 409 * e) >>> 8, 0, 255);
        rgb[15:8]  = clamp_byte((298 * c - 100 * d - 208 * e) >>> 8, 0, 255);
        rgb[7:0]   = clamp_byte((298 * c + 516 * d) >>> 8, 0, 255);
        return rgb;
    endfunction

    function automatic ryc_pkg::out_word_t converted_pair(ryc_pkg::in_word_t w, logic dir);
        ryc_pkg::out_word_t o;
        int                 b0;
        int                 b1;
        int                 b2;
        int                 b3;
        int                 b4;
        int                 b5;
        b0 = w.in_byte_0;
        b1 = w.in_byte_1;
        b2 = w.in_byte_2;
        b3 = w.in_byte_3;
        b4 = w.in_byte_4;
        b5 = w.in_byte_5;
        if (dir == ryc_pkg::DIR_ENCODE)
        begin
            // Chroma is taken from the first pixel only.
            o.out_byte_0 = luma_of(b0, b1, b2);
            o.out_byte_1 = clamp_byte(((-38 * b0 - 74 * b1 + 112 * b2) >>> 8) + 128, 16, 240);
            o.out_byte_2 = luma_of(b3, b4, b5);
            o.out_byte_3 = clamp_byte(((112 * b0 - 94 * b1 - 18 * b2) >>> 8) + 128, 16, 240);
            o.out_byte_4 = 8'd0;
            o.out_byte_5 = 8'd0;
        end
        else
        begin
            {o.out_byte_0, o.out_byte_1, o.out_byte_2} = rgb_of(b0 - 16, b1 - 128, b3 - 128);
            {o.out_byte_3, o.out_byte_4, o.out_byte_5} = rgb_of(b2 - 16, b1 - 128, b3 - 128);
        end
        return o;
    endfunction

    // ---------------------------------------------------------------- result check

    task automatic check_byte(string field, logic [7:0] expected, logic [7:0] actual);
        if (actual !== expected)
        begin
            $error("%s: expected %0d, got %0d", field, expected, actual);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_words.size() == 0)
            begin
                $error("result word %h arrived with nothing expected", result);
                mismatch_count++;
            end
            else
            begin
                oldest_word = pending_words.pop_front();
                words_checked++;
                check_byte("out_byte_0", oldest_word.out_byte_0, result.out_byte_0);
                check_byte("out_byte_1", oldest_word.out_byte_1, result.out_byte_1);
                check_byte("out_byte_2", oldest_word.out_byte_2, result.out_byte_2);
                check_byte("out_byte_3", oldest_word.out_byte_3, result.out_byte_3);
                check_byte("out_byte_4", oldest_word.out_byte_4, result.out_byte_4);
                check_byte("out_byte_5", oldest_word.out_byte_5, result.out_byte_5);
            end
        end
    end

    // ---------------------------------------------------------------- driving

    task automatic send_word(ryc_pkg::in_word_t w);
        int gap;
        if (idle_enabled && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 13);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        in_word <= w;
        do
            @(posedge clk);
        while (busy);
        pending_words.push_back(converted_pair(w, direction_copy));
        if (direction_copy == ryc_pkg::DIR_ENCODE)
            encode_count++;
        else
            decode_count++;
    endtask

    task automatic send_bytes(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                              logic [7:0] b3, logic [7:0] b4, logic [7:0] b5);
        ryc_pkg::in_word_t w;
        w = '{b0, b1, b2, b3, b4, b5};
        send_word(w);
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        start <= 1'b0;
        while (pending_words.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_words.size() != 0)
        begin
            $error("%0d result words never arrived", pending_words.size());
            mismatch_count += pending_words.size();
            pending_words.delete();
        end
    endtask

    task automatic write_direction(logic dir);
        drain_results();
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= dir;
        @(posedge clk);
        cfg_we         <= 1'b0;
        direction_copy = dir;
        direction_writes++;
    endtask

    // Corner values show up often so that clamps are hit in the random part too.
    function automatic logic [7:0] random_byte();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic ryc_pkg::in_word_t random_pair();
        ryc_pkg::in_word_t w;
        w = '{random_byte(), random_byte(), random_byte(),
              random_byte(), random_byte(), random_byte()};
        return w;
    endfunction

    // ---------------------------------------------------------------- tests

    // Encoding runs on the reset value of the direction register.
    task automatic test_encode_corners();
        send_bytes(8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0);
        send_bytes(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        send_bytes(8'd255, 8'd0,   8'd0,   8'd0,   8'd0,   8'd255);
        send_bytes(8'd0,   8'd255, 8'd0,   8'd255, 8'd255, 8'd0);
        send_bytes(8'd0,   8'd0,   8'd255, 8'd0,   8'd255, 8'd255);
        send_bytes(8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   8'd0);
        send_bytes(8'd0,   8'd255, 8'd255, 8'd128, 8'd128, 8'd128);
        send_bytes(8'hA5,  8'h5A,  8'hC3,  8'h3C,  8'h0F,  8'hF0);
    endtask

    task automatic test_decode_corners();
        write_direction(ryc_pkg::DIR_DECODE);
        // The last two bytes are ignored here, so they carry noise.
        send_bytes(8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd255);
        send_bytes(8'd255, 8'd255, 8'd255, 8'd255, 8'hA5,  8'h5A);
        send_bytes(8'd16,  8'd128, 8'd235, 8'd128, 8'd0,   8'd0);
        send_bytes(8'd255, 8'd0,   8'd0,   8'd255, 8'h3C,  8'hC3);
        send_bytes(8'd0,   8'd255, 8'd255, 8'd0,   8'd1,   8'd128);
        send_bytes(8'd128, 8'd0,   8'd128, 8'd255, 8'd77,  8'd200);
        send_bytes(8'd235, 8'd240, 8'd16,  8'd16,  8'd255, 8'd0);
        send_bytes(8'd15,  8'd127, 8'd17,  8'd129, 8'h55,  8'hAA);
    endtask

    task automatic test_random_phases();
        logic dir_plan [6];
        dir_plan = '{ryc_pkg::DIR_ENCODE, ryc_pkg::DIR_DECODE, ryc_pkg::DIR_DECODE,
                     ryc_pkg::DIR_ENCODE, ryc_pkg::DIR_DECODE, ryc_pkg::DIR_ENCODE};
        foreach (dir_plan[p])
        begin
            write_direction(dir_plan[p]);
            for (int i = 0; i < 250; i++)
            begin
                // Idling switches on and off in stretches of 40 words.
                if (i % 40 == 0)
                    idle_enabled = ($urandom_range(0, 2) != 0);
                send_word(random_pair());
            end
        end
        idle_enabled = 1'b0;
    endtask

    task automatic test_back_to_back();
        idle_enabled = 1'b0;
        write_direction(ryc_pkg::DIR_DECODE);
        repeat (100) send_word(random_pair());
        write_direction(ryc_pkg::DIR_ENCODE);
        repeat (100) send_word(random_pair());
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= 1'b0;
        start     <= 1'b0;
        in_word   <= '0;
        direction_copy   = ryc_pkg::DIR_ENCODE;
        idle_enabled     = 1'b1;
        mismatch_count   = 0;
        words_checked    = 0;
        encode_count     = 0;
        decode_count     = 0;
        direction_writes = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_encode_corners();
        test_decode_corners();
        test_random_phases();
        test_back_to_back();

        drain_results();
        repeat (8) @(posedge clk);

        $display("Sent %0d encode and %0d decode pixel pairs over %0d direction writes.",
                 encode_count, decode_count, direction_writes);
        $display("Checked %0d result words, %0d mismatches.", words_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
